### src/rlt_pkg.sv
`timescale 1ns / 1ps

package rlt_pkg;

  // Default table geometry
  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned DefHandleBits = 16;

  // Request modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DUP          = 3'd1,
    ST_OVERLAP      = 3'd2,
    ST_FULL         = 3'd3,
    ST_NOTFOUND     = 3'd4,
    ST_OVL_NOTFOUND = 3'd5
  } rlt_status_e;

  // Outcome of the table scan
  typedef enum logic [1:0] {
    FIND_NONE = 2'd0,
    FIND_HIT  = 2'd1,
    FIND_OVL  = 2'd2
  } rlt_find_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FIN,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } rlt_state_e;

  // Compare unit result
  typedef struct packed {
    logic hit;
    logic ovl;
  } rlt_match_t;

endpackage

### src/rlt_match.sv
`timescale 1ns / 1ps

module rlt_match
  import rlt_pkg::*;
#(
  parameter int unsigned HandleBits = DefHandleBits
) (
  input  logic [HandleBits-1:0] req_hdl_i,
  input  logic [31:0]           req_start_i,
  input  logic [31:0]           req_len_i,
  input  logic signed [33:0]    req_last_i,
  input  logic [HandleBits-1:0] ent_hdl_i,
  input  logic [31:0]           ent_start_i,
  input  logic [31:0]           ent_len_i,
  input  logic signed [33:0]    ent_last_i,
  output rlt_match_t            match_o
);

  logic signed [33:0] np;
  logic signed [33:0] es;
  logic               heq;
  logic               exact;
  logic               isect;

  // Inclusive bounds check; an empty span (hi below lo) never contains anything
  function automatic logic in_span(logic signed [33:0] x, logic signed [33:0] lo,
                                   logic signed [33:0] hi);
    in_span = (x >= lo) && (x <= hi);
  endfunction

  assign np = signed'({2'b00, req_start_i});
  assign es = signed'({2'b00, ent_start_i});

  // Only entries of the same owner take part
  assign heq   = (req_hdl_i == ent_hdl_i);
  assign exact = (req_start_i == ent_start_i) && (req_len_i == ent_len_i);
  assign isect = in_span(es, np, req_last_i) || in_span(ent_last_i, np, req_last_i) ||
                 in_span(np, es, ent_last_i) || in_span(req_last_i, es, ent_last_i);

  assign match_o.hit = heq && exact;
  assign match_o.ovl = heq && !exact && isect;

endmodule

### src/range_lock_table.sv
// Each request scans the table entries (up to TABLE_DEPTH) through a shared compare
// unit, reading an entry from the table memory (S_RD) and then comparing it (S_CMP);
// after a removal, the entries above the freed slot are moved down (S_SH_RD, S_SH_WR).
// One request at a time; a new request is taken once the previous one has reached
// the output register, so a stalled result holds off the next request. Reset empties
// the table at once (fill count).
`timescale 1ns / 1ps

module range_lock_table
  import rlt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned HANDLE_BITS = DefHandleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] owner_handle_i,
  input  logic [31:0] range_start_i,
  input  logic [31:0] range_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [4:0]  lock_count_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW = HANDLE_BITS;

  // Table memory, one array per field, entries 0..count-1 valid
  logic [HW-1:0]      mem_hdl   [TABLE_DEPTH];
  logic [31:0]        mem_start [TABLE_DEPTH];
  logic [31:0]        mem_len   [TABLE_DEPTH];
  logic signed [33:0] mem_last  [TABLE_DEPTH];

  logic [HW-1:0]      rd_hdl_q;
  logic [31:0]        rd_start_q;
  logic [31:0]        rd_len_q;
  logic signed [33:0] rd_last_q;

  // Sequencer and request registers
  rlt_state_e         state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  rlt_find_e          found_q, found_d;
  rlt_status_e        status_q, status_d;
  logic               mode_q;
  logic [HW-1:0]      hdl_q;
  logic [31:0]        start_q;
  logic [31:0]        len_q;
  logic signed [33:0] last_q;

  // Output register
  logic               out_valid_q, out_valid_d;
  rlt_status_e        out_status_q;
  logic [4:0]         out_count_q;
  logic               out_load;

  // Memory port controls
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [HW-1:0]      wr_hdl;
  logic [31:0]        wr_start;
  logic [31:0]        wr_len;
  logic signed [33:0] wr_last;

  logic               in_xfer;
  logic [CW-1:0]      idx_ext;
  rlt_match_t         match;

  assign in_xfer = in_valid_i && in_ready_o;
  assign idx_ext = CW'(idx_q);

  // Shared compare unit on the registered read data
  rlt_match #(
    .HandleBits(HW)
  ) u_match (
    .req_hdl_i  (hdl_q),
    .req_start_i(start_q),
    .req_len_i  (len_q),
    .req_last_i (last_q),
    .ent_hdl_i  (rd_hdl_q),
    .ent_start_i(rd_start_q),
    .ent_len_i  (rd_len_q),
    .ent_last_i (rd_last_q),
    .match_o    (match)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (count_q == '0) ? S_FIN : S_RD;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (match.hit || match.ovl || (idx_ext + 1'b1 == count_q)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (mode_q == MODE_REMOVE && found_q == FIND_HIT && idx_ext + 1'b1 < count_q) begin
          state_d = S_SH_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = (idx_ext + 1'b1 < count_q) ? S_SH_RD : S_RESP;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_hdl      = rd_hdl_q;
    wr_start    = rd_start_q;
    wr_len      = rd_len_q;
    wr_last     = rd_last_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        found_d    = FIND_NONE;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_CMP: begin
        if (match.hit) begin
          found_d = FIND_HIT;
        end else if (match.ovl) begin
          found_d = FIND_OVL;
        end else if (idx_ext + 1'b1 != count_q) begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        if (mode_q == MODE_RECORD) begin
          priority case (1'b1)
            found_q == FIND_HIT: status_d = ST_DUP;
            found_q == FIND_OVL: status_d = ST_OVERLAP;
            count_q == CW'(TABLE_DEPTH): status_d = ST_FULL;
            default: begin
              status_d = ST_OK;
              wr_en    = 1'b1;
              wr_addr  = count_q[IW-1:0];
              wr_hdl   = hdl_q;
              wr_start = start_q;
              wr_len   = len_q;
              wr_last  = last_q;
              count_d  = count_q + 1'b1;
            end
          endcase
        end else begin
          priority case (found_q)
            FIND_HIT: begin
              status_d = ST_OK;
              count_d  = count_q - 1'b1;
            end
            FIND_OVL: status_d = ST_OVL_NOTFOUND;
            default:  status_d = ST_NOTFOUND;
          endcase
        end
      end
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q + 1'b1;
      end
      S_SH_WR: begin
        // Close the gap: entry idx+1 moves down to idx
        wr_en = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      S_RESP: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      found_q     <= FIND_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (in_xfer) begin
      mode_q  <= mode_i;
      hdl_q   <= HW'(owner_handle_i);
      start_q <= range_start_i;
      len_q   <= range_length_i;
      last_q  <= signed'({2'b00, range_start_i} + {2'b00, range_length_i} - 34'd1);
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= 5'(count_q);
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_hdl[wr_addr]   <= wr_hdl;
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
      mem_last[wr_addr]  <= wr_last;
    end
    if (rd_en) begin
      rd_hdl_q   <= mem_hdl[rd_addr];
      rd_start_q <= mem_start[rd_addr];
      rd_len_q   <= mem_len[rd_addr];
      rd_last_q  <= mem_last[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign lock_count_o = out_count_q;

`ifndef ASSERT_OFF
  // Fill count never exceeds the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("lock count above table depth");

  // Fill count only changes when a request is decided
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_FIN))
    else $error("lock count changed outside decision step");

  // Gap closing never reads past the last held entry
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_RD) |-> (idx_ext < count_q))
    else $error("shift index beyond held entries");
`endif

endmodule
